/* hw/rtl/crca_pkg.sv */
// Shared types and constants for the circle ring colour averaging block.
`default_nettype none

package crca_pkg;

	localparam int COORD_W   = 11;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CHAN_W    = 8;
	localparam int NCH       = 3;
	localparam int SUM_W     = 24;
	localparam int CNT_W     = 16;
	localparam int SQ_W      = 2 * COORD_W;
	localparam int NUM_W     = SUM_W + 2;
	localparam int AVG_W     = 8;
	localparam int DIV_STEPS = AVG_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_RADIUS = 2'd2;

	localparam logic [COORD_W-1:0] RADIUS_RESET = COORD_W'(1);

	localparam int CH_BLUE  = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED   = 2;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CALC = 5'b00010,
		S_ACC  = 5'b00100,
		S_DIV  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	typedef struct packed {
		logic load_in;
		logic calc;
		logic acc;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic out_full;
	} status_t;

endpackage

`default_nettype wire

/* hw/rtl/circle_ring_colour_average.sv */
// Top level of the circle ring colour averaging block.
//
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  pixel    | in_valid/in_stall, pixel_x, pixel_y, *_in,     | in
//           | frame_end                                      |
//  result   | out_valid/out_stall, *_avg, ring_count         | out
//  config   | cfg_wr_en, cfg_index, cfg_data                 | in
//
// Each pixel transaction is accepted, squared, then compared and accumulated.
// A frame_end pixel adds eight steps of the bit-per-cycle restoring dividers and a load of
// the output register; a full output register holds that load.
// Reset sets the center to 0, the radius to 1 and clears all sums and the count.
// The next pixel is taken while a result waits in the output register.
`default_nettype none

module circle_ring_colour_average (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire [crca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [crca_pkg::CFG_W-1:0]     cfg_data,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire [crca_pkg::COORD_W-1:0]   pixel_x,
	input  wire [crca_pkg::COORD_W-1:0]   pixel_y,
	input  wire [crca_pkg::CHAN_W-1:0]    blue_in,
	input  wire [crca_pkg::CHAN_W-1:0]    green_in,
	input  wire [crca_pkg::CHAN_W-1:0]    red_in,
	input  wire                           frame_end,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [crca_pkg::AVG_W-1:0]    blue_avg,
	output logic [crca_pkg::AVG_W-1:0]    green_avg,
	output logic [crca_pkg::AVG_W-1:0]    red_avg,
	output logic [crca_pkg::CNT_W-1:0]    ring_count
);
	import crca_pkg::*;

	cmd_t    cmd;
	status_t status;

	crca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	crca_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.blue_in    (blue_in),
		.green_in   (green_in),
		.red_in     (red_in),
		.frame_end  (frame_end),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.blue_avg   (blue_avg),
		.green_avg  (green_avg),
		.red_avg    (red_avg),
		.ring_count (ring_count)
	);

endmodule

`default_nettype wire

/* hw/rtl/crca_ctrl.sv */
// Sequencing state machine for the circle ring colour averaging block.
`default_nettype none

module crca_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  crca_pkg::status_t  status,
	output crca_pkg::cmd_t     cmd
);
	import crca_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] step_q;
	logic              last_step;

	assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));
	assign in_stall  = (state_q != S_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (status.frame_end) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				// Wait here until the previous result has left the output register.
				if (!status.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !status.out_full)
		else $error("result loaded over an unread result");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> ##(DIV_STEPS + 1) (state_q == S_FIN))
		else $error("divider did not run for the expected number of steps");

	a_acc_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> ($past(state_q) == S_CALC))
		else $error("accumulate without a preceding square step");

endmodule

`default_nettype wire

/* hw/rtl/crca_datapath.sv */
// Ring test, accumulators, restoring dividers and output register.
`default_nettype none

module crca_datapath (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_wr_en,
	input  wire [crca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [crca_pkg::CFG_W-1:0]   cfg_data,
	input  wire [crca_pkg::COORD_W-1:0] pixel_x,
	input  wire [crca_pkg::COORD_W-1:0] pixel_y,
	input  wire [crca_pkg::CHAN_W-1:0]  blue_in,
	input  wire [crca_pkg::CHAN_W-1:0]  green_in,
	input  wire [crca_pkg::CHAN_W-1:0]  red_in,
	input  wire                         frame_end,
	input  crca_pkg::cmd_t              cmd,
	output crca_pkg::status_t           status,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [crca_pkg::AVG_W-1:0]  blue_avg,
	output logic [crca_pkg::AVG_W-1:0]  green_avg,
	output logic [crca_pkg::AVG_W-1:0]  red_avg,
	output logic [crca_pkg::CNT_W-1:0]  ring_count
);
	import crca_pkg::*;

	logic [COORD_W-1:0] center_x_q;
	logic [COORD_W-1:0] center_y_q;
	logic [COORD_W-1:0] radius_q;

	logic [COORD_W-1:0] px_q;
	logic [COORD_W-1:0] py_q;
	logic [CHAN_W-1:0]  chan_q [NCH];
	logic               fend_q;

	logic [COORD_W-1:0] dx;
	logic [COORD_W-1:0] dy;
	logic [COORD_W-1:0] a_w;
	logic [COORD_W-1:0] b_w;

	logic [SQ_W-1:0]    a2_q;
	logic [SQ_W-1:0]    b2_q;
	logic [SQ_W-1:0]    r2_q;
	logic [COORD_W-1:0] b_q;

	logic [SQ_W-1:0]    diff;
	logic [SQ_W-1:0]    lo_bound;
	logic [SQ_W:0]      hi_bound;
	logic               hit;
	logic               take;

	logic [SUM_W-1:0]   sum_q   [NCH];
	logic [SUM_W-1:0]   sum_nxt [NCH];
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_nxt;

	logic [NUM_W-1:0]   rem_q   [NCH];
	logic [AVG_W-1:0]   quo_q   [NCH];
	logic [NUM_W-1:0]   den_sh_q;
	logic [CNT_W-1:0]   cnt_res_q;

	logic               out_valid_q;
	logic [AVG_W-1:0]   avg_out_q [NCH];
	logic [CNT_W-1:0]   count_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= RADIUS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CENTER_X:    center_x_q <= COORD_W'(cfg_data);
				CFG_CENTER_Y:    center_y_q <= COORD_W'(cfg_data);
				CFG_RING_RADIUS: radius_q   <= COORD_W'(cfg_data);
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q             <= pixel_x;
			py_q             <= pixel_y;
			chan_q[CH_BLUE]  <= blue_in;
			chan_q[CH_GREEN] <= green_in;
			chan_q[CH_RED]   <= red_in;
			fend_q           <= frame_end;
		end
	end

	assign dx  = (px_q >= center_x_q) ? (px_q - center_x_q) : (center_x_q - px_q);
	assign dy  = (py_q >= center_y_q) ? (py_q - center_y_q) : (center_y_q - py_q);
	assign a_w = (dx < dy) ? dx : dy;
	assign b_w = (dx < dy) ? dy : dx;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			a2_q <= SQ_W'(a_w) * SQ_W'(a_w);
			b2_q <= SQ_W'(b_w) * SQ_W'(b_w);
			r2_q <= SQ_W'(radius_q) * SQ_W'(radius_q);
			b_q  <= b_w;
		end
	end

	// With d = r*r - a*a the rounding test reduces to b*b - b < d <= b*b + b.
	assign diff     = r2_q - a2_q;
	assign lo_bound = b2_q - SQ_W'(b_q);
	assign hi_bound = {1'b0, b2_q} + (SQ_W + 1)'(b_q);
	assign hit      = (r2_q >= a2_q) && (diff > lo_bound) && ({1'b0, diff} <= hi_bound);
	assign take     = hit && (cnt_q != '1);

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			sum_nxt[i] = take ? (sum_q[i] + SUM_W'(chan_q[i])) : sum_q[i];
		end
		cnt_nxt = take ? (cnt_q + CNT_W'(1)) : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				sum_q[i] <= '0;
			end
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			for (int i = 0; i < NCH; i++) begin
				sum_q[i] <= '0;
			end
			cnt_q <= '0;
		end else if (cmd.acc) begin
			for (int i = 0; i < NCH; i++) begin
				sum_q[i] <= sum_nxt[i];
			end
			cnt_q <= cnt_nxt;
		end
	end

	// Restoring division of (2*sum + n) by 2*n, one quotient bit per step,
	// starting from the divisor shifted up to the top quotient bit.
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			for (int i = 0; i < NCH; i++) begin
				rem_q[i] <= {sum_nxt[i], 1'b0} + NUM_W'(cnt_nxt);
				quo_q[i] <= '0;
			end
			den_sh_q  <= NUM_W'({cnt_nxt, 1'b0}) << (DIV_STEPS - 1);
			cnt_res_q <= cnt_nxt;
		end else if (cmd.div_step) begin
			for (int i = 0; i < NCH; i++) begin
				if (rem_q[i] >= den_sh_q) begin
					rem_q[i] <= rem_q[i] - den_sh_q;
					quo_q[i] <= {quo_q[i][AVG_W-2:0], 1'b1};
				end else begin
					quo_q[i] <= {quo_q[i][AVG_W-2:0], 1'b0};
				end
			end
			den_sh_q <= den_sh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			for (int i = 0; i < NCH; i++) begin
				avg_out_q[i] <= (cnt_res_q == '0) ? '0 : quo_q[i];
			end
			count_out_q <= cnt_res_q;
		end
	end

	assign status.frame_end = fend_q;
	assign status.out_full  = out_valid_q;

	assign out_valid  = out_valid_q;
	assign blue_avg   = avg_out_q[CH_BLUE];
	assign green_avg  = avg_out_q[CH_GREEN];
	assign red_avg    = avg_out_q[CH_RED];
	assign ring_count = count_out_q;

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (cnt_q == '0))
		else $error("hit count not cleared at end of frame");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc && !cmd.div_start) |=> (cnt_q - $past(cnt_q) <= CNT_W'(1)))
		else $error("hit count advanced by more than one");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(count_out_q)))
		else $error("stalled result changed");

endmodule

`default_nettype wire

/* sim/circle_ring_colour_average_test.sv */
// Testbench for the circle ring colour averaging block with its own frame summary predictor.
`timescale 1ns / 100ps

import crca_pkg::*;

typedef struct packed {
	logic [AVG_W-1:0] blue;
	logic [AVG_W-1:0] green;
	logic [AVG_W-1:0] red;
	logic [CNT_W-1:0] count;
} frame_summary_t;

class ring_average_tracker;
	logic [COORD_W-1:0] center_x = '0;
	logic [COORD_W-1:0] center_y = '0;
	logic [COORD_W-1:0] radius = RADIUS_RESET;
	logic [SUM_W-1:0] blue_sum = '0;
	logic [SUM_W-1:0] green_sum = '0;
	logic [SUM_W-1:0] red_sum = '0;
	logic [CNT_W-1:0] hits = '0;
	frame_summary_t summaries_due[$];
	int errors = 0;

	function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		case (idx)
			CFG_CENTER_X: center_x = value;
			CFG_CENTER_Y: center_y = value;
			CFG_RING_RADIUS: radius = value;
			default: ;
		endcase
	endfunction

	// Rounded-sqrt test done in integers: (2b-1)^2 <= 4(r^2 - a^2) < (2b+1)^2.
	function bit on_ring(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
		longint dx, dy, a, b, r, v4;
		dx = (px >= center_x) ? longint'(px) - longint'(center_x)
				: longint'(center_x) - longint'(px);
		dy = (py >= center_y) ? longint'(py) - longint'(center_y)
				: longint'(center_y) - longint'(py);
		a = (dx < dy) ? dx : dy;
		b = (dx < dy) ? dy : dx;
		r = longint'(radius);
		v4 = 4 * (r * r - a * a);
		return ((2 * b - 1) * (2 * b - 1) <= v4) && (v4 < (2 * b + 1) * (2 * b + 1));
	endfunction

	function logic [AVG_W-1:0] rounded_mean(logic [SUM_W-1:0] sum);
		longint n;
		n = longint'(hits);
		if (n == 0)
			return '0;
		return AVG_W'((2 * longint'(sum) + n) / (2 * n));
	endfunction

	function void take_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
			logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] r, logic last);
		frame_summary_t s;
		// A saturated count freezes the sums for the rest of the frame.
		if (on_ring(px, py) && hits != '1) begin
			blue_sum = blue_sum + SUM_W'(b);
			green_sum = green_sum + SUM_W'(g);
			red_sum = red_sum + SUM_W'(r);
			hits = hits + 1'b1;
		end
		if (last) begin
			s.blue = rounded_mean(blue_sum);
			s.green = rounded_mean(green_sum);
			s.red = rounded_mean(red_sum);
			s.count = hits;
			summaries_due.push_back(s);
			blue_sum = '0;
			green_sum = '0;
			red_sum = '0;
			hits = '0;
		end
	endfunction

	function void compare_summary(logic [AVG_W-1:0] b, logic [AVG_W-1:0] g,
			logic [AVG_W-1:0] r, logic [CNT_W-1:0] cnt);
		frame_summary_t s;
		if (summaries_due.size() == 0) begin
			$error("unexpected result transaction: blue_avg %0d green_avg %0d red_avg %0d ring_count %0d",
					b, g, r, cnt);
			errors++;
			return;
		end
		s = summaries_due.pop_front();
		if (b !== s.blue) begin
			$error("blue_avg: expected %0d, actual %0d", s.blue, b);
			errors++;
		end
		if (g !== s.green) begin
			$error("green_avg: expected %0d, actual %0d", s.green, g);
			errors++;
		end
		if (r !== s.red) begin
			$error("red_avg: expected %0d, actual %0d", s.red, r);
			errors++;
		end
		if (cnt !== s.count) begin
			$error("ring_count: expected %0d, actual %0d", s.count, cnt);
			errors++;
		end
	endfunction
endclass

module circle_ring_colour_average_test;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_PIXELS = 1450;
	localparam int COORD_MAX = (1 << COORD_W) - 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [COORD_W-1:0] pixel_x = '0;
	logic [COORD_W-1:0] pixel_y = '0;
	logic [CHAN_W-1:0] blue_in = '0;
	logic [CHAN_W-1:0] green_in = '0;
	logic [CHAN_W-1:0] red_in = '0;
	logic frame_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [AVG_W-1:0] blue_avg;
	logic [AVG_W-1:0] green_avg;
	logic [AVG_W-1:0] red_avg;
	logic [CNT_W-1:0] ring_count;

	ring_average_tracker tracker;
	int burst_left = 0;
	int pixels_sent = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int stall_phase = 0;

	always #1 clk = ~clk;

	circle_ring_colour_average DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.blue_in(blue_in),
		.green_in(green_in),
		.red_in(red_in),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.blue_avg(blue_avg),
		.green_avg(green_avg),
		.red_avg(red_avg),
		.ring_count(ring_count)
	);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.compare_summary(blue_avg, green_avg, red_avg, ring_count);
	end

	// The receiver switches between stall patterns, each held for a random span.
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			stall_mode = stall_mode_t'($urandom_range(3, 0));
			stall_phase = $urandom_range(96, 16);
		end
		stall_phase--;
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(3, 0) != 0);
			default: out_stall <= (stall_phase % 5 < 3);
		endcase
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
		tracker.write_register(idx, CFG_W'(value));
	endtask

	task automatic configure(input int cx, input int cy, input int r);
		write_register(CFG_CENTER_X, cx);
		write_register(CFG_CENTER_Y, cy);
		write_register(CFG_RING_RADIUS, r);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_pixel(input int px, input int py, input int b, input int g,
			input int r, input logic last);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(10, 1)) @(posedge clk);
			burst_left = $urandom_range(32, 1);
		end
		in_valid <= 1'b1;
		pixel_x <= COORD_W'(px);
		pixel_y <= COORD_W'(py);
		blue_in <= CHAN_W'(b);
		green_in <= CHAN_W'(g);
		red_in <= CHAN_W'(r);
		frame_end <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_pixel(COORD_W'(px), COORD_W'(py), CHAN_W'(b), CHAN_W'(g), CHAN_W'(r),
				last);
		if (burst_left > 0)
			burst_left--;
	endtask

	// Registers change only once every frame summary has come out.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (tracker.summaries_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int place(input int c, input int d);
		int p;
		p = $urandom_range(1, 0) ? c + d : c - d;
		if (p > COORD_MAX || p < 0)
			p = (p > c) ? c - d : c + d;
		if (p < 0)
			p = 0;
		if (p > COORD_MAX)
			p = COORD_MAX;
		return p;
	endfunction

	// Picks a pixel on or right next to the rasterized circle.
	task automatic ring_point(output int px, output int py);
		int r, a, b;
		real root;
		r = tracker.radius;
		a = $urandom_range(r, 0);
		root = $sqrt(r * r - a * a);
		b = $rtoi(root + 0.5);
		if ($urandom_range(3, 0) == 0)
			b = b + int'($urandom_range(2, 0)) - 1;
		if (b < 0)
			b = 0;
		if ($urandom_range(1, 0)) begin
			px = place(tracker.center_x, a);
			py = place(tracker.center_y, b);
		end else begin
			px = place(tracker.center_x, b);
			py = place(tracker.center_y, a);
		end
	endtask

	function automatic int pick_colour();
		case ($urandom_range(7, 0))
			0: return 0;
			1: return 255;
			default: return $urandom_range(255, 0);
		endcase
	endfunction

	function automatic int pick_center();
		case ($urandom_range(3, 0))
			0: return 0;
			1: return COORD_MAX;
			default: return $urandom_range(COORD_MAX, 0);
		endcase
	endfunction

	function automatic int pick_radius();
		case ($urandom_range(6, 0))
			0: return 0;
			1: return 1;
			2: return COORD_MAX;
			6: return $urandom_range(COORD_MAX, 0);
			default: return $urandom_range(60, 1);
		endcase
	endfunction

	initial begin
		int len, px, py;
		tracker = new;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: center at the origin, radius one.
		send_pixel(1, 0, 255, 0, 128, 1'b0);
		send_pixel(0, 1, 0, 255, 127, 1'b0);
		send_pixel(0, 0, 9, 9, 9, 1'b0);
		send_pixel(1, 1, 7, 7, 7, 1'b1);
		// A frame with no ring pixels reports zeros.
		send_pixel(COORD_MAX, COORD_MAX, 255, 255, 255, 1'b1);

		settle();
		configure(0, 0, COORD_MAX);
		send_pixel(COORD_MAX, 0, 255, 255, 255, 1'b0);
		send_pixel(0, COORD_MAX, 255, 254, 0, 1'b0);
		send_pixel(COORD_MAX, COORD_MAX, 1, 2, 3, 1'b0);
		send_pixel(1448, 1448, 200, 100, 50, 1'b1);

		settle();
		configure(COORD_MAX, COORD_MAX, COORD_MAX);
		send_pixel(0, COORD_MAX, 10, 20, 30, 1'b0);
		send_pixel(COORD_MAX, 0, 11, 21, 31, 1'b0);
		send_pixel(0, 0, 12, 22, 32, 1'b1);

		// Radius zero: even the center pixel misses.
		settle();
		configure(1024, 1024, 0);
		send_pixel(1024, 1024, 50, 60, 70, 1'b0);
		send_pixel(1025, 1024, 50, 60, 70, 1'b1);

		// The spare index must be ignored; the means are rounded to the nearest integer.
		settle();
		write_register(CFG_SPARE, COORD_MAX);
		configure(100, 200, 5);
		send_pixel(105, 200, 1, 0, 255, 1'b0);
		send_pixel(100, 195, 2, 1, 254, 1'b0);
		send_pixel(103, 204, 1, 0, 255, 1'b0);
		send_pixel(104, 203, 2, 1, 254, 1'b0);
		send_pixel(95, 200, 0, 0, 0, 1'b1);

		while (pixels_sent < RANDOM_PIXELS) begin
			if ($urandom_range(2, 0) == 0) begin
				settle();
				configure(pick_center(), pick_center(), pick_radius());
			end
			len = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 41) : $urandom_range(40, 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(9, 0) < 7) begin
					ring_point(px, py);
				end else begin
					px = $urandom_range(COORD_MAX, 0);
					py = $urandom_range(COORD_MAX, 0);
				end
				send_pixel(px, py, pick_colour(), pick_colour(), pick_colour(), i == len - 1);
				pixels_sent++;
			end
		end

		settle();
		if (tracker.errors == 0 && tracker.summaries_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
